// ===== hw/rtl/tard_pkg.sv =====
// Shared types, constants and the CORDIC arctangent table for the tilt-to-RGB duty block.
// No dependencies; every other file in hw/rtl imports this package.
package tard_pkg;

  localparam int SAMPLE_BITS = 12;
  localparam int DUTY_BITS = 10;
  localparam int ANGLE_BITS_DEF = 16;
  localparam int CORDIC_STEPS = 28;
  // 2^30 divided by the CORDIC gain
  localparam logic signed [31:0] CORDIC_GAIN_INV = 32'sd652032874;
  localparam logic [DUTY_BITS-1:0] DUTY_FULL_SCALE_RESET = 10'd100;
  localparam int SAMPLE_SCALE_SHIFT = 20;
  localparam int SINE_BITS = 16;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] accel_x;
    logic signed [SAMPLE_BITS-1:0] accel_y;
  } sample_t;

  typedef struct packed {
    logic [DUTY_BITS-1:0] red_duty;
    logic [DUTY_BITS-1:0] green_duty;
    logic [DUTY_BITS-1:0] blue_duty;
  } duty_t;

  // atan(2^-i) in units of 2^-32 turn
  function automatic logic [31:0] atan_turn(input int idx);
    logic [31:0] a;
    case (idx)
      0:  a = 32'h20000000;
      1:  a = 32'h12E4051E;
      2:  a = 32'h09FB385B;
      3:  a = 32'h051111D4;
      4:  a = 32'h028B0D43;
      5:  a = 32'h0145D7E1;
      6:  a = 32'h00A2F61E;
      7:  a = 32'h00517C55;
      8:  a = 32'h0028BE53;
      9:  a = 32'h00145F2F;
      10: a = 32'h000A2F98;
      11: a = 32'h000517CC;
      12: a = 32'h00028BE6;
      13: a = 32'h000145F3;
      14: a = 32'h0000A2FA;
      15: a = 32'h0000517D;
      16: a = 32'h000028BE;
      17: a = 32'h0000145F;
      18: a = 32'h00000A30;
      19: a = 32'h00000518;
      20: a = 32'h0000028C;
      21: a = 32'h00000146;
      22: a = 32'h000000A3;
      23: a = 32'h00000051;
      24: a = 32'h00000029;
      25: a = 32'h00000014;
      26: a = 32'h0000000A;
      27: a = 32'h00000005;
      default: a = 32'h00000000;
    endcase
    return a;
  endfunction

endpackage

// ===== hw/rtl/tard_vector.sv =====
// Pipelined vectoring CORDIC: atan2(x, y) as an ANGLE_BITS fraction of a turn.
// Depends on tard_pkg.
module tard_vector #(
  parameter int ANGLE_BITS = tard_pkg::ANGLE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  in_valid,
  input  tard_pkg::sample_t     sample,
  output logic                  out_valid,
  output logic [ANGLE_BITS-1:0] theta
);
  import tard_pkg::*;

  localparam int VW = SAMPLE_BITS + SAMPLE_SCALE_SHIFT + 3;
  localparam logic [31:0] HALF_LSB = 32'd1 << (31 - ANGLE_BITS);

  logic signed [VW-1:0] re [0:CORDIC_STEPS];
  logic signed [VW-1:0] im [0:CORDIC_STEPS];
  logic [31:0]          z  [0:CORDIC_STEPS];
  logic                 zero [0:CORDIC_STEPS];
  logic                 vld  [0:CORDIC_STEPS];

  logic signed [VW-1:0] re_next [0:CORDIC_STEPS-1];
  logic signed [VW-1:0] im_next [0:CORDIC_STEPS-1];
  logic [31:0]          z_next  [0:CORDIC_STEPS-1];

  logic signed [VW-1:0] xs, ys;
  logic [31:0]          z_round;

  // scale samples and pre-rotate by a half turn when y is negative
  always_comb begin
    xs = VW'(sample.accel_x) <<< SAMPLE_SCALE_SHIFT;
    ys = VW'(sample.accel_y) <<< SAMPLE_SCALE_SHIFT;
  end

  always_comb begin
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      if (!im[i][VW-1]) begin
        re_next[i] = re[i] + (im[i] >>> i);
        im_next[i] = im[i] - (re[i] >>> i);
        z_next[i]  = z[i] + atan_turn(i);
      end else begin
        re_next[i] = re[i] - (im[i] >>> i);
        im_next[i] = im[i] + (re[i] >>> i);
        z_next[i]  = z[i] - atan_turn(i);
      end
    end
  end

  assign z_round = z[CORDIC_STEPS] + HALF_LSB;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i <= CORDIC_STEPS; i++) vld[i] <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
      for (int i = 0; i < CORDIC_STEPS; i++) vld[i+1] <= vld[i];
      out_valid <= vld[CORDIC_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (ys[VW-1]) begin
        re[0] <= -ys;
        im[0] <= -xs;
        z[0]  <= 32'h80000000;
      end else begin
        re[0] <= ys;
        im[0] <= xs;
        z[0]  <= 32'h00000000;
      end
      zero[0] <= (sample.accel_x == '0) && (sample.accel_y == '0);
      for (int i = 0; i < CORDIC_STEPS; i++) begin
        re[i+1]   <= re_next[i];
        im[i+1]   <= im_next[i];
        z[i+1]    <= z_next[i];
        zero[i+1] <= zero[i];
      end
      theta <= zero[CORDIC_STEPS] ? '0 : z_round[31 -: ANGLE_BITS];
    end
  end

endmodule

// ===== hw/rtl/tard_sine.sv =====
// Pipelined rotation CORDIC: Q1.15 sine of (angle + PHASE), fraction-of-turn angle.
// Depends on tard_pkg.
module tard_sine #(
  parameter int                    ANGLE_BITS = tard_pkg::ANGLE_BITS_DEF,
  parameter logic [ANGLE_BITS-1:0] PHASE      = '0
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  en,
  input  logic                                  in_valid,
  input  logic [ANGLE_BITS-1:0]                 angle,
  output logic                                  out_valid,
  output logic signed [tard_pkg::SINE_BITS-1:0] sine
);
  import tard_pkg::*;

  logic [ANGLE_BITS-1:0] ang;
  logic                  ang_valid;

  logic signed [31:0] x [0:CORDIC_STEPS];
  logic signed [31:0] y [0:CORDIC_STEPS];
  logic signed [32:0] z [0:CORDIC_STEPS];
  logic               vld [0:CORDIC_STEPS];

  logic signed [31:0] x_next [0:CORDIC_STEPS-1];
  logic signed [31:0] y_next [0:CORDIC_STEPS-1];
  logic signed [32:0] z_next [0:CORDIC_STEPS-1];

  logic [31:0]        u, u_fold;
  logic signed [32:0] y_sum, r;
  logic signed [SINE_BITS-1:0] r_sat;

  // fold into [-1/4, 1/4] turn: quadrants two and three mirror about 1/4 turn
  always_comb begin
    u = {ang, {(32 - ANGLE_BITS){1'b0}}};
    if (u[31] ^ u[30]) u_fold = 32'h80000000 - u;
    else u_fold = u;
  end

  always_comb begin
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      if (!z[i][32]) begin
        x_next[i] = x[i] - (y[i] >>> i);
        y_next[i] = y[i] + (x[i] >>> i);
        z_next[i] = z[i] - $signed({1'b0, atan_turn(i)});
      end else begin
        x_next[i] = x[i] + (y[i] >>> i);
        y_next[i] = y[i] - (x[i] >>> i);
        z_next[i] = z[i] + $signed({1'b0, atan_turn(i)});
      end
    end
  end

  // round half up to Q1.15, then saturate
  always_comb begin
    y_sum = 33'(y[CORDIC_STEPS]) + 33'sd16384;
    r     = y_sum >>> 15;
    if (r > 33'sd32767) r_sat = 16'sh7FFF;
    else if (r < -33'sd32768) r_sat = 16'sh8000;
    else r_sat = r[SINE_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ang_valid <= 1'b0;
      for (int i = 0; i <= CORDIC_STEPS; i++) vld[i] <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      ang_valid <= in_valid;
      vld[0]    <= ang_valid;
      for (int i = 0; i < CORDIC_STEPS; i++) vld[i+1] <= vld[i];
      out_valid <= vld[CORDIC_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ang  <= angle + PHASE;
      x[0] <= CORDIC_GAIN_INV;
      y[0] <= '0;
      z[0] <= 33'($signed(u_fold));
      for (int i = 0; i < CORDIC_STEPS; i++) begin
        x[i+1] <= x_next[i];
        y[i+1] <= y_next[i];
        z[i+1] <= z_next[i];
      end
      sine <= r_sat;
    end
  end

endmodule

// ===== hw/rtl/tard_duty.sv =====
// Duty stage: m = 0.5 + 0.5*sine in Q0.16, then round(full_scale * m^2 / 2^32).
// Depends on tard_pkg.
module tard_duty (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  en,
  input  logic                                  in_valid,
  input  logic signed [tard_pkg::SINE_BITS-1:0] sine,
  input  logic [tard_pkg::DUTY_BITS-1:0]        full_scale,
  output logic                                  out_valid,
  output logic [tard_pkg::DUTY_BITS-1:0]        duty
);
  import tard_pkg::*;

  localparam int SQ_BITS = 2 * SINE_BITS;
  localparam int PR_BITS = SQ_BITS + DUTY_BITS;

  logic [SINE_BITS-1:0] m;
  logic [SQ_BITS-1:0]   sq;
  logic [PR_BITS-1:0]   prod;
  logic [PR_BITS:0]     prod_round;
  logic                 sq_valid, prod_valid;

  // 32768 + s just flips the sign bit
  assign m          = {~sine[SINE_BITS-1], sine[SINE_BITS-2:0]};
  assign prod_round = {1'b0, prod} + ((PR_BITS + 1)'(1) << (SQ_BITS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_valid   <= 1'b0;
      prod_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else if (en) begin
      sq_valid   <= in_valid;
      prod_valid <= sq_valid;
      out_valid  <= prod_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq   <= SQ_BITS'(m) * SQ_BITS'(m);
      prod <= PR_BITS'(full_scale) * PR_BITS'(sq);
      duty <= prod_round[SQ_BITS +: DUTY_BITS];
    end
  end

endmodule

// ===== hw/rtl/tilt_angle_to_rgb_duty_core.sv =====
// Top level: tilt angle of an X/Y acceleration word to red, green, blue PWM duty counts.
// Depends on tard_pkg, tard_vector, tard_sine and tard_duty.
//
//  channel | handshake                  | word
//  --------+----------------------------+------------------------------------
//  sample  | sample_valid / sample_stall| sample_t: accel_x, accel_y
//  duty    | duty_valid / duty_stall    | duty_t: red_duty, green_duty, blue_duty
//  config  | cfg_we                     | cfg_data: duty_full_scale (10 bits)
//
// One word in per cycle, one word out per cycle while no output word is held;
// the pipe runs through the atan2 CORDIC, one sine CORDIC per lane, then square/scale.
// rst (synchronous) clears all valid bits and loads duty_full_scale = 100.
// A stalled output word freezes the whole pipe; sample_stall then rises in
// the same cycle, so nothing is dropped or repeated. Bubbles travel freely.
module tilt_angle_to_rgb_duty_core #(
  parameter int ANGLE_BITS = tard_pkg::ANGLE_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           sample_valid,
  output logic                           sample_stall,
  input  tard_pkg::sample_t              sample,
  output logic                           duty_valid,
  input  logic                           duty_stall,
  output tard_pkg::duty_t                duty,
  input  logic                           cfg_we,
  input  logic [tard_pkg::DUTY_BITS-1:0] cfg_data
);
  import tard_pkg::*;

  // phase offsets of 1/3 and 2/3 turn, rounded to the nearest angle code
  localparam longint OFF1 = ((64'd1 << (ANGLE_BITS + 1)) + 64'd3) / 64'd6;
  localparam longint OFF2 = ((64'd2 << (ANGLE_BITS + 1)) + 64'd3) / 64'd6;
  localparam logic [ANGLE_BITS-1:0] PHASE [0:2] = '{
    '0, OFF1[ANGLE_BITS-1:0], OFF2[ANGLE_BITS-1:0]
  };

  logic                  en;
  logic [DUTY_BITS-1:0]  full_scale;
  logic                  theta_valid;
  logic [ANGLE_BITS-1:0] theta;

  logic                        sine_valid [0:2];
  logic signed [SINE_BITS-1:0] sine       [0:2];
  logic                        lane_valid [0:2];
  logic [DUTY_BITS-1:0]        lane_duty  [0:2];

  // whole pipe advances unless the output word is held
  assign en           = !(duty_valid && duty_stall);
  assign sample_stall = !en;

  always_ff @(posedge clk) begin
    if (rst) begin
      full_scale <= DUTY_FULL_SCALE_RESET;
    end else if (cfg_we) begin
      full_scale <= cfg_data;
    end
  end

  tard_vector #(.ANGLE_BITS(ANGLE_BITS)) u_vector (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (sample_valid),
    .sample    (sample),
    .out_valid (theta_valid),
    .theta     (theta)
  );

  // lane 0 red, lane 1 green, lane 2 blue
  for (genvar k = 0; k < 3; k++) begin : g_lane
    tard_sine #(.ANGLE_BITS(ANGLE_BITS), .PHASE(PHASE[k])) u_sine (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (theta_valid),
      .angle     (theta),
      .out_valid (sine_valid[k]),
      .sine      (sine[k])
    );

    tard_duty u_duty (
      .clk        (clk),
      .rst        (rst),
      .en         (en),
      .in_valid   (sine_valid[k]),
      .sine       (sine[k]),
      .full_scale (full_scale),
      .out_valid  (lane_valid[k]),
      .duty       (lane_duty[k])
    );
  end

  assign duty_valid       = lane_valid[0];
  assign duty.red_duty    = lane_duty[0];
  assign duty.green_duty  = lane_duty[1];
  assign duty.blue_duty   = lane_duty[2];

  // the three lanes march in lock step
  a_lanes_aligned: assert property (@(posedge clk) disable iff (rst)
    (lane_valid[0] == lane_valid[1]) && (lane_valid[0] == lane_valid[2]))
    else $error("color lanes out of step");

  // m^2 never exceeds 1.0, so no duty passes the full-scale count
  a_duty_bounded: assert property (@(posedge clk) disable iff (rst)
    duty_valid |-> (duty.red_duty <= full_scale) && (duty.green_duty <= full_scale)
                   && (duty.blue_duty <= full_scale))
    else $error("duty above full scale");

  // nothing emerges in the first cycle after reset
  a_empty_after_reset: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !duty_valid)
    else $error("output valid straight after reset");

endmodule

// ===== dv/testbench.sv =====
// Self-checking bench for tilt_angle_to_rgb_duty_core: X/Y tilt words in, RGB duty words out.
// Depends on tard_pkg (word types, widths, reset full scale) and the core RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import tard_pkg::*;

  localparam int ANGLE_BITS = ANGLE_BITS_DEF;
  localparam int STEPS = CORDIC_STEPS;
  // Pipe is 64 deep; pause a bit longer than that before register writes and at the end
  localparam int SETTLE_CYCLES = 80;
  localparam longint GAIN_COMP = 64'd652032874;

  // Phase offsets of green and blue, one third and two thirds of a turn, rounded
  localparam logic [ANGLE_BITS-1:0] THIRD_TURN =
    ANGLE_BITS'(((64'd1 << (ANGLE_BITS + 1)) + 64'd3) / 64'd6);
  localparam logic [ANGLE_BITS-1:0] TWO_THIRDS_TURN =
    ANGLE_BITS'(((64'd2 << (ANGLE_BITS + 1)) + 64'd3) / 64'd6);

  // atan(2^-i) in 2^-32 turn units, element 0 first
  localparam logic [0:STEPS-1][31:0] ARCTAN_TURNS = {
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
    32'h00000014, 32'h0000000A, 32'h00000005
  };

  logic clk;
  logic rst = 1'b1;
  logic sample_valid = 1'b0;
  logic sample_stall;
  sample_t sample = '0;
  logic duty_valid;
  logic duty_stall = 1'b0;
  duty_t duty;
  logic cfg_we = 1'b0;
  logic [DUTY_BITS-1:0] cfg_data = '0;

  // Bench copy of the full-scale register; only changes while the pipe is empty
  logic [DUTY_BITS-1:0] full_scale = DUTY_FULL_SCALE_RESET;

  sample_t pending_samples[$];   // words waiting to be offered
  duty_t expected_duties[$];     // predictions for accepted words, oldest first
  int send_idle_pct = 0;
  int stall_pct = 0;
  int mismatch_count = 0;

  tilt_angle_to_rgb_duty_core u_dut (
    .clk(clk),
    .rst(rst),
    .sample_valid(sample_valid),
    .sample_stall(sample_stall),
    .sample(sample),
    .duty_valid(duty_valid),
    .duty_stall(duty_stall),
    .duty(duty),
    .cfg_we(cfg_we),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Tilt angle atan2(x, y) as an ANGLE_BITS fraction of a turn.
  // Vectoring CORDIC on the samples scaled by 2^20; left half plane is
  // pre-rotated by half a turn. Zero vector gives angle 0.
  function automatic logic [ANGLE_BITS-1:0] tilt_angle(input logic signed [SAMPLE_BITS-1:0] ax,
                                                       input logic signed [SAMPLE_BITS-1:0] ay);
    longint re, im, dr, di;
    logic [31:0] acc;
    logic [63:0] rounded;
    if (ax == 0 && ay == 0) begin
      return '0;
    end
    re = longint'(ay) <<< SAMPLE_SCALE_SHIFT;
    im = longint'(ax) <<< SAMPLE_SCALE_SHIFT;
    acc = 32'h0;
    if (re < 0) begin
      re = -re;
      im = -im;
      acc = 32'h80000000;
    end
    for (int i = 0; i < STEPS; i++) begin
      dr = im >>> i;
      di = re >>> i;
      if (im >= 0) begin
        re = re + dr;
        im = im - di;
        acc = acc + ARCTAN_TURNS[i];
      end else begin
        re = re - dr;
        im = im + di;
        acc = acc - ARCTAN_TURNS[i];
      end
    end
    // round half up to ANGLE_BITS, wrapping at one turn
    rounded = {32'h0, acc} + (64'd1 << (31 - ANGLE_BITS));
    return ANGLE_BITS'(rounded >> (32 - ANGLE_BITS));
  endfunction

  // Q1.15 sine via rotation CORDIC; angle folded into [-1/4, 1/4] turn first
  function automatic int sine_q15(input logic [ANGLE_BITS-1:0] ang);
    logic [31:0] u;
    longint px, py, pz, dx, dy, r;
    u = 32'(ang) << (32 - ANGLE_BITS);
    if (u >= 32'h40000000 && u < 32'hC0000000) begin
      u = 32'h80000000 - u;
    end
    pz = longint'($signed(u));
    px = GAIN_COMP;
    py = 0;
    for (int i = 0; i < STEPS; i++) begin
      dx = py >>> i;
      dy = px >>> i;
      if (pz >= 0) begin
        px = px - dx;
        py = py + dy;
        pz = pz - longint'({32'h0, ARCTAN_TURNS[i]});
      end else begin
        px = px + dx;
        py = py - dy;
        pz = pz + longint'({32'h0, ARCTAN_TURNS[i]});
      end
    end
    r = (py + 64'sd16384) >>> 15;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return int'(r);
  endfunction

  // duty = round(fs * ((1 + s) / 2)^2), computed as fs * m^2 / 2^32 with m in Q0.16
  function automatic logic [DUTY_BITS-1:0] duty_count(input logic [ANGLE_BITS-1:0] ang,
                                                      input logic [DUTY_BITS-1:0] fs);
    longint unsigned m, prod;
    m = longint'(32768 + sine_q15(ang));
    prod = 64'(fs) * m * m + 64'h80000000;
    return DUTY_BITS'(prod >> 32);
  endfunction

  function automatic duty_t predict_rgb(input sample_t s, input logic [DUTY_BITS-1:0] fs);
    logic [ANGLE_BITS-1:0] theta;
    duty_t d;
    theta = tilt_angle(s.accel_x, s.accel_y);
    d.red_duty = duty_count(theta, fs);
    d.green_duty = duty_count(theta + THIRD_TURN, fs);
    d.blue_duty = duty_count(theta + TWO_THIRDS_TURN, fs);
    return d;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: offers queued words; predicts each one at the edge it is taken
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : sample_driver
    logic taken;
    if (rst) begin
      sample_valid <= 1'b0;
    end else begin
      taken = sample_valid && !sample_stall;
      if (taken) begin
        expected_duties.push_back(predict_rgb(sample, full_scale));
      end
      // a held word stays put until it is taken
      if (!sample_valid || taken) begin
        if (pending_samples.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          sample <= pending_samples.pop_front();
          sample_valid <= 1'b1;
        end else begin
          sample_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: random stall, field-by-field compare against the oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : duty_monitor
    duty_t want;
    if (rst) begin
      duty_stall <= 1'b0;
    end else begin
      if (duty_valid && !duty_stall) begin
        if (expected_duties.size() == 0) begin
          $error("duty word with no sample pending: %h", duty);
          mismatch_count++;
        end else begin
          want = expected_duties.pop_front();
          if (duty.red_duty !== want.red_duty) begin
            $error("red_duty: expected %0d, got %0d", want.red_duty, duty.red_duty);
            mismatch_count++;
          end
          if (duty.green_duty !== want.green_duty) begin
            $error("green_duty: expected %0d, got %0d", want.green_duty, duty.green_duty);
            mismatch_count++;
          end
          if (duty.blue_duty !== want.blue_duty) begin
            $error("blue_duty: expected %0d, got %0d", want.blue_duty, duty.blue_duty);
            mismatch_count++;
          end
        end
      end
      duty_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  // Wait for the pipe to empty, then let it settle before touching the register
  task automatic drain();
    do @(negedge clk);
    while (pending_samples.size() != 0 || sample_valid || expected_duties.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic load_full_scale(input logic [DUTY_BITS-1:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    full_scale = value;
  endtask

  // Mix of full-range words and the corners: near-zero vectors, axes,
  // diagonals, rail values and y just below zero (the half-turn fold seam)
  task automatic queue_random_samples(input int count);
    sample_t s;
    for (int n = 0; n < count; n++) begin
      s = sample_t'($urandom);
      case ($urandom_range(9))
        4: begin
          s.accel_x = SAMPLE_BITS'($urandom_range(16)) - SAMPLE_BITS'(8);
          s.accel_y = SAMPLE_BITS'($urandom_range(16)) - SAMPLE_BITS'(8);
        end
        5: begin
          if ($urandom_range(1)) s.accel_x = '0;
          else s.accel_y = '0;
        end
        6: s.accel_y = $urandom_range(1) ? s.accel_x : -s.accel_x;
        7: begin
          s.accel_x = $urandom_range(1) ? 12'sh7FF : 12'sh800;
          s.accel_y = $urandom_range(2) == 0 ? 12'sh000 :
                      ($urandom_range(1) ? 12'sh7FF : 12'sh800);
        end
        8: s.accel_y = -SAMPLE_BITS'($urandom_range(4, 1));
        default: ;
      endcase
      pending_samples.push_back(s);
    end
  endtask

  initial begin : stimulus
    sample_t s;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // sender idles lightly, receiver stalls heavily
    send_idle_pct = 19;
    stall_pct = 70;

    // directed words at the reset full scale: zero vector, axes, rails,
    // diagonals and unit steps around the origin
    pending_samples.push_back('{accel_x: 12'sh000, accel_y: 12'sh000});
    pending_samples.push_back('{accel_x: 12'sh7FF, accel_y: 12'sh000});
    pending_samples.push_back('{accel_x: 12'sh800, accel_y: 12'sh000});
    pending_samples.push_back('{accel_x: 12'sh000, accel_y: 12'sh7FF});
    pending_samples.push_back('{accel_x: 12'sh000, accel_y: 12'sh800});
    pending_samples.push_back('{accel_x: 12'sh7FF, accel_y: 12'sh7FF});
    pending_samples.push_back('{accel_x: 12'sh800, accel_y: 12'sh800});
    pending_samples.push_back('{accel_x: 12'sh7FF, accel_y: 12'sh800});
    pending_samples.push_back('{accel_x: 12'sh800, accel_y: 12'sh7FF});
    pending_samples.push_back('{accel_x: 12'sh001, accel_y: 12'sh000});
    pending_samples.push_back('{accel_x: 12'sh000, accel_y: 12'sh001});
    pending_samples.push_back('{accel_x: 12'shFFF, accel_y: 12'sh000});
    pending_samples.push_back('{accel_x: 12'sh000, accel_y: 12'shFFF});
    pending_samples.push_back('{accel_x: 12'shFFF, accel_y: 12'shFFF});
    pending_samples.push_back('{accel_x: 12'sh001, accel_y: 12'shFFF});
    pending_samples.push_back('{accel_x: 12'shFFF, accel_y: 12'sh001});
    pending_samples.push_back('{accel_x: 12'sh001, accel_y: 12'sh001});
    pending_samples.push_back('{accel_x: 12'sh800, accel_y: 12'shFFF});
    pending_samples.push_back('{accel_x: 12'sh800, accel_y: 12'sh001});
    pending_samples.push_back('{accel_x: 12'sh005, accel_y: 12'sh800});
    pending_samples.push_back('{accel_x: 12'sh555, accel_y: 12'shAAA});
    pending_samples.push_back('{accel_x: 12'shAAA, accel_y: 12'sh555});
    drain();

    // largest full scale
    load_full_scale(10'd1023);
    queue_random_samples(400);
    drain();

    // roles swapped: sender idles heavily, receiver stalls lightly
    send_idle_pct = 70;
    stall_pct = 19;
    // zero full scale: every duty must come out 0
    load_full_scale(10'd0);
    s = '{accel_x: 12'sh000, accel_y: 12'sh000};
    pending_samples.push_back(s);
    queue_random_samples(100);
    drain();

    load_full_scale(10'd1);
    queue_random_samples(300);
    drain();

    // back-to-back traffic, no idling on either side
    send_idle_pct = 0;
    stall_pct = 0;
    load_full_scale(DUTY_BITS'($urandom_range(1022, 2)));
    queue_random_samples(400);
    drain();

    load_full_scale(DUTY_FULL_SCALE_RESET);
    queue_random_samples(300);
    drain();

    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run
  initial begin : watchdog
    #2000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/tard_pkg.sv
hw/rtl/tard_vector.sv
hw/rtl/tard_sine.sv
hw/rtl/tard_duty.sv
hw/rtl/tilt_angle_to_rgb_duty_core.sv
dv/testbench.sv
